@@ design/pru_pkg.sv @@
// Shared types, constants and the Paeth helper function for the PNG row unfilter core.
package pru_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int ROW_BYTES_W   = 14;
  localparam int PIXEL_BYTES_W = 4;
  localparam int CFG_DATA_W    = 14;
  localparam int CFG_IDX_W     = 1;
  localparam int BYTE_W        = 8;

  localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int SLOT_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int CMP_W  = COL_W + ROW_BYTES_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  localparam logic [BYTE_W-1:0] FILT_MAX_CODE = BYTE_W'(FILT_PAETH);

  typedef enum logic [1:0] {
    OP_DROP  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_ERROR = 2'd2,
    OP_DATA  = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    filter_e           filter;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
    logic              first_row;
    logic              last;
  } s1_item_t;

  function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b,
                                                   input logic [BYTE_W-1:0] c);
    logic signed [BYTE_W+2:0] da;
    logic signed [BYTE_W+2:0] db;
    logic signed [BYTE_W+2:0] dc;
    logic [BYTE_W+2:0]        pa;
    logic [BYTE_W+2:0]        pb;
    logic [BYTE_W+2:0]        pc;
    logic [BYTE_W-1:0]        pick;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[BYTE_W+2] ? $unsigned(-da) : $unsigned(da);
    pb = db[BYTE_W+2] ? $unsigned(-db) : $unsigned(db);
    pc = dc[BYTE_W+2] ? $unsigned(-dc) : $unsigned(dc);
    if (pa <= pb && pa <= pc) begin
      pick = a;
    end else if (pb <= pc) begin
      pick = b;
    end else begin
      pick = c;
    end
    return pick;
  endfunction

endpackage

@@ design/png_row_unfilter_core.sv @@
// Top level of the PNG scanline reconstruction core (None/Sub/Up/Average/Paeth).
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid_i in_stall_o in_byte_i           | in_valid_i && !in_stall_o
//          | start_of_image_i                          |
//  out     | out_valid_o out_stall_i out_byte_o        | out_valid_o && !out_stall_i
//          | row_end_o status_o                        |
//  cfg     | cfg_we_i cfg_idx_i cfg_data_i             | cfg_we_i
//
// One byte per cycle sustained unless the output stalls; a result passes through the
// reconstruction stage and output registers. The rate is set by the row memory, one read
// and one write port per cycle, with same-column write-to-read forwarding. Reset clears
// control state and the neighbor registers; the row memory needs no clearing. An output
// stall holds the output register and, once the reconstruction stage is also full, the input.
module png_row_unfilter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pru_pkg::BYTE_W-1:0]     in_byte_i,
  input  logic                           start_of_image_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pru_pkg::BYTE_W-1:0]     out_byte_o,
  output logic                           row_end_o,
  output logic                           status_o
);

  logic                          in_fire;
  pru_pkg::s1_item_t             item;
  logic                          ram_re;
  logic [pru_pkg::COL_W-1:0]     ram_raddr;
  logic [pru_pkg::BYTE_W-1:0]    ram_rdata;
  logic                          ram_we;
  logic [pru_pkg::COL_W-1:0]     ram_waddr;
  logic [pru_pkg::BYTE_W-1:0]    ram_wdata;

  assign in_fire = in_valid_i && !in_stall_o;

  pru_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_fire_i        (in_fire),
    .in_byte_i        (in_byte_i),
    .start_of_image_i (start_of_image_i),
    .item_o           (item)
  );

  pru_ram #(
    .WIDTH (pru_pkg::BYTE_W),
    .DEPTH (pru_pkg::MAX_ROW_BYTES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pru_recon u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .item_i      (item),
    .in_stall_o  (in_stall_o),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .row_end_o   (row_end_o),
    .status_o    (status_o)
  );

endmodule

@@ design/pru_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pru_seq.sv @@
// Row sequencing: configuration registers, column and slot tracking, item decode.
module pru_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pru_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_fire_i,
  input  logic [pru_pkg::BYTE_W-1:0]        in_byte_i,
  input  logic                              start_of_image_i,
  output pru_pkg::s1_item_t                 item_o
);

  logic [pru_pkg::ROW_BYTES_W-1:0]   row_bytes_q;
  logic [pru_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_q;
  logic [pru_pkg::COL_W-1:0]         column_q, column_d;
  pru_pkg::filter_e                  filter_q, filter_d;
  logic                              expect_q, expect_d;
  logic                              first_row_q, first_row_d;
  logic                              halted_q, halted_d;
  logic [pru_pkg::SLOT_W-1:0]        cnt_q [pru_pkg::MAX_PIXEL_BYTES];
  logic [pru_pkg::SLOT_W-1:0]        cnt_d [pru_pkg::MAX_PIXEL_BYTES];

  logic [pru_pkg::CMP_W-1:0]         rb_eff;
  logic [pru_pkg::PIXEL_BYTES_W-1:0] pb_eff;
  logic [pru_pkg::SLOT_W-1:0]        pb_sel;
  logic                              last;
  logic                              eff_expect;
  logic                              eff_halted;
  logic                              eff_first;
  logic [pru_pkg::COL_W-1:0]         eff_col;

  always_comb begin
    if (row_bytes_q == '0) begin
      rb_eff = pru_pkg::CMP_W'(1);
    end else if (pru_pkg::CMP_W'(row_bytes_q) > pru_pkg::CMP_W'(pru_pkg::MAX_ROW_BYTES)) begin
      rb_eff = pru_pkg::CMP_W'(pru_pkg::MAX_ROW_BYTES);
    end else begin
      rb_eff = pru_pkg::CMP_W'(row_bytes_q);
    end
    if (pixel_bytes_q == '0) begin
      pb_eff = pru_pkg::PIXEL_BYTES_W'(1);
    end else if (int'(pixel_bytes_q) > pru_pkg::MAX_PIXEL_BYTES) begin
      pb_eff = pru_pkg::PIXEL_BYTES_W'(pru_pkg::MAX_PIXEL_BYTES);
    end else begin
      pb_eff = pixel_bytes_q;
    end
    pb_sel = pru_pkg::SLOT_W'(pb_eff - pru_pkg::PIXEL_BYTES_W'(1));
  end

  always_comb begin
    eff_expect  = expect_q | start_of_image_i;
    eff_halted  = halted_q & ~start_of_image_i;
    eff_first   = first_row_q | start_of_image_i;
    eff_col     = start_of_image_i ? '0 : column_q;
    last        = (pru_pkg::CMP_W'(eff_col) + pru_pkg::CMP_W'(1)) >= rb_eff;

    column_d    = eff_col;
    filter_d    = filter_q;
    expect_d    = eff_expect;
    first_row_d = eff_first;
    halted_d    = eff_halted;
    cnt_d       = cnt_q;

    item_o.data      = in_byte_i;
    item_o.filter    = filter_q;
    item_o.slot      = cnt_q[pb_sel];
    item_o.col       = eff_col;
    item_o.first_row = eff_first;
    item_o.last      = last;
    item_o.op        = pru_pkg::OP_DROP;

    if (eff_halted) begin
      item_o.op = pru_pkg::OP_DROP;
    end else if (eff_expect) begin
      column_d = '0;
      for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
        cnt_d[k] = '0;
      end
      if (in_byte_i > pru_pkg::FILT_MAX_CODE) begin
        item_o.op = pru_pkg::OP_ERROR;
        halted_d  = 1'b1;
      end else begin
        item_o.op = pru_pkg::OP_CLEAR;
        filter_d  = pru_pkg::filter_e'(in_byte_i[2:0]);
        expect_d  = 1'b0;
      end
    end else begin
      item_o.op = pru_pkg::OP_DATA;
      if (last) begin
        column_d    = '0;
        expect_d    = 1'b1;
        first_row_d = 1'b0;
        for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
          cnt_d[k] = '0;
        end
      end else begin
        column_d = eff_col + pru_pkg::COL_W'(1);
        for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
          cnt_d[k] = (cnt_q[k] == pru_pkg::SLOT_W'(k)) ? '0 : cnt_q[k] + pru_pkg::SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= pru_pkg::ROW_BYTES_W'(1);
      pixel_bytes_q <= pru_pkg::PIXEL_BYTES_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pru_pkg::REG_ROW_BYTES) begin
        row_bytes_q <= cfg_data_i[pru_pkg::ROW_BYTES_W-1:0];
      end else if (cfg_idx_i == pru_pkg::REG_PIXEL_BYTES) begin
        pixel_bytes_q <= cfg_data_i[pru_pkg::PIXEL_BYTES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      filter_q    <= pru_pkg::FILT_NONE;
      expect_q    <= 1'b1;
      first_row_q <= 1'b1;
      halted_q    <= 1'b0;
      for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
        cnt_q[k] <= '0;
      end
    end else if (in_fire_i) begin
      column_q    <= column_d;
      filter_q    <= filter_d;
      expect_q    <= expect_d;
      first_row_q <= first_row_d;
      halted_q    <= halted_d;
      cnt_q       <= cnt_d;
    end
  end

  // halted only after a bad filter byte, so a filter byte is still pending
  a_halted_expects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> expect_q)
    else $error("halted without pending filter byte");

  // a data byte that does not end its row leaves the column below the maximum row size
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && item_o.op == pru_pkg::OP_DATA && !item_o.last
    |=> pru_pkg::CMP_W'(column_q) < pru_pkg::CMP_W'(pru_pkg::MAX_ROW_BYTES))
    else $error("column past row end");

endmodule

@@ design/pru_recon.sv @@
// Reconstruction stage: predictor, neighbor registers, row write-back, output register.
module pru_recon (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  pru_pkg::s1_item_t             item_i,
  output logic                          in_stall_o,
  output logic                          ram_re_o,
  output logic [pru_pkg::COL_W-1:0]     ram_raddr_o,
  input  logic [pru_pkg::BYTE_W-1:0]    ram_rdata_i,
  output logic                          ram_we_o,
  output logic [pru_pkg::COL_W-1:0]     ram_waddr_o,
  output logic [pru_pkg::BYTE_W-1:0]    ram_wdata_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pru_pkg::BYTE_W-1:0]    out_byte_o,
  output logic                          row_end_o,
  output logic                          status_o
);

  pru_pkg::s1_item_t              s1_q;
  logic                           s1_valid_q;
  logic                           fwd_q;
  logic [pru_pkg::BYTE_W-1:0]     fwd_data_q;
  logic [pru_pkg::BYTE_W-1:0]     left_q [pru_pkg::MAX_PIXEL_BYTES];
  logic [pru_pkg::BYTE_W-1:0]     upleft_q [pru_pkg::MAX_PIXEL_BYTES];
  logic                           out_valid_q;
  logic [pru_pkg::BYTE_W-1:0]     out_byte_q;
  logic                           row_end_q;
  logic                           status_q;

  logic                           has_result;
  logic                           s1_fire;
  logic [pru_pkg::BYTE_W-1:0]     a, b, c, b_mem, pred, r;
  logic [pru_pkg::BYTE_W:0]       avg_sum;

  assign has_result = s1_q.op == pru_pkg::OP_DATA || s1_q.op == pru_pkg::OP_ERROR;
  assign s1_fire    = s1_valid_q && (!has_result || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;

  assign b_mem   = fwd_q ? fwd_data_q : ram_rdata_i;
  assign a       = left_q[s1_q.slot];
  assign c       = upleft_q[s1_q.slot];
  assign b       = s1_q.first_row ? '0 : b_mem;
  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1_q.filter)
      pru_pkg::FILT_NONE:  pred = '0;
      pru_pkg::FILT_SUB:   pred = a;
      pru_pkg::FILT_UP:    pred = b;
      pru_pkg::FILT_AVG:   pred = avg_sum[pru_pkg::BYTE_W:1];
      pru_pkg::FILT_PAETH: pred = pru_pkg::paeth_pick(a, b, c);
      default:             pred = '0;
    endcase
    r = s1_q.data + pred;
  end

  assign ram_re_o    = in_fire_i;
  assign ram_raddr_o = item_i.col;
  assign ram_we_o    = s1_fire && s1_q.op == pru_pkg::OP_DATA;
  assign ram_waddr_o = s1_q.col;
  assign ram_wdata_o = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire_i) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // write of the same column retiring on the accept edge is forwarded
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_q       <= item_i;
      fwd_q      <= ram_we_o && ram_waddr_o == item_i.col;
      fwd_data_q <= r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
        left_q[k]   <= '0;
        upleft_q[k] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_q.op == pru_pkg::OP_DATA) begin
        left_q[s1_q.slot]   <= r;
        upleft_q[s1_q.slot] <= b;
      end else if (s1_q.op == pru_pkg::OP_CLEAR || s1_q.op == pru_pkg::OP_ERROR) begin
        for (int k = 0; k < pru_pkg::MAX_PIXEL_BYTES; k++) begin
          left_q[k]   <= '0;
          upleft_q[k] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_result) begin
      out_byte_q <= (s1_q.op == pru_pkg::OP_DATA) ? r : '0;
      row_end_q  <= (s1_q.op == pru_pkg::OP_DATA) && s1_q.last;
      status_q   <= s1_q.op == pru_pkg::OP_ERROR;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign row_end_o   = row_end_q;
  assign status_o    = status_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && has_result && out_valid_q)
    else $error("input stalled without a blocked result");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && has_result |=> out_valid_q)
    else $error("retired result not registered");

  a_error_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q |-> out_byte_q == '0 && !row_end_q)
    else $error("error transaction carries data");

  a_fwd_only_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i && ram_we_o && ram_waddr_o == item_i.col |=> fwd_q)
    else $error("same-column write not forwarded");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for png_row_unfilter_core: scanline reconstruction against a predictor.
module tb;

  localparam logic ST_OK         = 1'b0;
  localparam logic ST_BAD_FILTER = 1'b1;
  localparam int   RANDOM_ITEMS  = 1250;
  localparam int   TAIL_ITEMS    = 150;
  localparam int   WIDE_ITEMS    = 120;
  localparam int   LIMIT_CYCLES  = 3_000_000;

  typedef struct packed {
    logic [pru_pkg::BYTE_W-1:0] data;
    logic                       last;
    logic                       status;
  } pixel_t;

  logic                           clk_i            = 1'b0;
  logic                           rst_ni           = 1'b0;
  logic                           cfg_we_i         = 1'b0;
  logic [pru_pkg::CFG_IDX_W-1:0]  cfg_idx_i        = '0;
  logic [pru_pkg::CFG_DATA_W-1:0] cfg_data_i       = '0;
  logic                           in_valid_i       = 1'b0;
  logic                           in_stall_o;
  logic [pru_pkg::BYTE_W-1:0]     in_byte_i        = '0;
  logic                           start_of_image_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i      = 1'b0;
  logic [pru_pkg::BYTE_W-1:0]     out_byte_o;
  logic                           row_end_o;
  logic                           status_o;

  // predictor state
  logic [pru_pkg::BYTE_W-1:0]        prev_line [pru_pkg::MAX_ROW_BYTES];
  logic [pru_pkg::BYTE_W-1:0]        left_px   [pru_pkg::MAX_PIXEL_BYTES];
  logic [pru_pkg::BYTE_W-1:0]        upleft_px [pru_pkg::MAX_PIXEL_BYTES];
  int                                col_q;
  pru_pkg::filter_e                  kind_q;
  bit                                want_filter;
  bit                                first_line;
  bit                                halted_q;
  logic [pru_pkg::ROW_BYTES_W-1:0]   row_bytes_q;
  logic [pru_pkg::PIXEL_BYTES_W-1:0] pixel_bytes_q;
  int                                written_hw;

  pixel_t expected_pixels[$];
  int     live_items;
  int     mismatch_count;
  bit     quiet;
  bit     gaps_on;
  bit     stall_on;
  int     stall_left;

  png_row_unfilter_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .start_of_image_i(start_of_image_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .row_end_o       (row_end_o),
    .status_o        (status_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  function automatic logic [pru_pkg::BYTE_W-1:0] paeth_choose(
    input logic [pru_pkg::BYTE_W-1:0] a,
    input logic [pru_pkg::BYTE_W-1:0] b,
    input logic [pru_pkg::BYTE_W-1:0] c);
    int est;
    int da;
    int db;
    int dc;
    est = int'(a) + int'(b) - int'(c);
    da  = (est >= int'(a)) ? est - int'(a) : int'(a) - est;
    db  = (est >= int'(b)) ? est - int'(b) : int'(b) - est;
    dc  = (est >= int'(c)) ? est - int'(c) : int'(c) - est;
    if (da <= db && da <= dc) begin
      return a;
    end else if (db <= dc) begin
      return b;
    end
    return c;
  endfunction

  // advance the predictor by one accepted byte; queue the pixel it produces, if any
  task automatic reconstruct_byte(input logic [pru_pkg::BYTE_W-1:0] x, input logic soi);
    int                         rb;
    int                         pb;
    int                         c;
    int                         slot;
    logic [pru_pkg::BYTE_W-1:0] a;
    logic [pru_pkg::BYTE_W-1:0] b;
    logic [pru_pkg::BYTE_W-1:0] ul;
    logic [pru_pkg::BYTE_W-1:0] pred;
    logic [pru_pkg::BYTE_W-1:0] r;
    pixel_t                     px;
    rb = (row_bytes_q == 0) ? 1 :
         (row_bytes_q > pru_pkg::MAX_ROW_BYTES) ? pru_pkg::MAX_ROW_BYTES : int'(row_bytes_q);
    pb = (pixel_bytes_q == 0) ? 1 :
         (pixel_bytes_q > pru_pkg::MAX_PIXEL_BYTES) ? pru_pkg::MAX_PIXEL_BYTES :
         int'(pixel_bytes_q);
    if (soi) begin
      halted_q    = 1'b0;
      first_line  = 1'b1;
      want_filter = 1'b1;
      col_q       = 0;
    end
    if (halted_q) return;
    live_items++;
    if (want_filter) begin
      foreach (left_px[i]) begin
        left_px[i]   = '0;
        upleft_px[i] = '0;
      end
      col_q = 0;
      if (x > pru_pkg::FILT_MAX_CODE) begin
        halted_q = 1'b1;
        px = '{data: '0, last: 1'b0, status: ST_BAD_FILTER};
        expected_pixels.push_back(px);
        return;
      end
      kind_q      = pru_pkg::filter_e'(x[2:0]);
      want_filter = 1'b0;
      return;
    end
    c    = (col_q >= pru_pkg::MAX_ROW_BYTES) ? pru_pkg::MAX_ROW_BYTES - 1 : col_q;
    slot = c % pb;
    a    = left_px[slot];
    ul   = upleft_px[slot];
    b    = first_line ? '0 : prev_line[c];
    case (kind_q)
      pru_pkg::FILT_SUB:   pred = a;
      pru_pkg::FILT_UP:    pred = b;
      pru_pkg::FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
      pru_pkg::FILT_PAETH: pred = paeth_choose(a, b, ul);
      default:             pred = '0;
    endcase
    r               = x + pred;
    left_px[slot]   = r;
    upleft_px[slot] = b;
    prev_line[c]    = r;
    if (c + 1 > written_hw) written_hw = c + 1;
    px = '{data: r, last: (c + 1 >= rb), status: ST_OK};
    if (c + 1 >= rb) begin
      col_q       = 0;
      want_filter = 1'b1;
      first_line  = 1'b0;
    end else begin
      col_q = c + 1;
    end
    expected_pixels.push_back(px);
  endtask

  task automatic send_item(input logic [pru_pkg::BYTE_W-1:0] b, input logic soi);
    logic s;
    int   c;
    s = soi;
    c = (col_q >= pru_pkg::MAX_ROW_BYTES) ? pru_pkg::MAX_ROW_BYTES - 1 : col_q;
    // never read a previous-row column that was never written: restart instead
    if (!s && !halted_q && !want_filter && !first_line && c >= written_hw) s = 1'b1;
    @(negedge clk_i);
    if (gaps_on && !quiet && $urandom_range(3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_byte_i        = b;
    start_of_image_i = s;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    reconstruct_byte(b, s);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pru_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pru_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == pru_pkg::REG_ROW_BYTES) begin
      row_bytes_q = val[pru_pkg::ROW_BYTES_W-1:0];
    end else begin
      pixel_bytes_q = val[pru_pkg::PIXEL_BYTES_W-1:0];
    end
  endtask

  task automatic send_row(input logic [pru_pkg::BYTE_W-1:0] code, input logic soi);
    send_item(code, soi);
    while (!want_filter && !halted_q) begin
      if ($urandom_range(63) == 0) begin
        send_item(8'($urandom_range(0, 5)), 1'b1);
      end else begin
        send_item(8'($urandom), 1'b0);
      end
    end
  endtask

  task automatic send_image(input int rows, input bit fresh);
    logic [pru_pkg::BYTE_W-1:0] code;
    while (!want_filter && !halted_q) send_item(8'($urandom), 1'b0);
    for (int r = 0; r < rows; r++) begin
      code = ($urandom_range(15) == 0) ? 8'($urandom_range(5, 255)) : 8'($urandom_range(0, 4));
      send_row(code, fresh && r == 0);
      if (halted_q) begin
        repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
        return;
      end
    end
  endtask

  task automatic test_filter_types();
    // reset registers: one-byte rows, one-byte pixels
    send_item(8'(pru_pkg::FILT_NONE), 1'b1);
    send_item(8'hA5, 1'b0);
    wait_idle();
    write_reg(pru_pkg::REG_ROW_BYTES, 14'd3);
    write_reg(pru_pkg::REG_PIXEL_BYTES, 14'd2);
    send_item(8'(pru_pkg::FILT_SUB), 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'(pru_pkg::FILT_UP), 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hFE, 1'b0);
    send_item(8'(pru_pkg::FILT_AVG), 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'(pru_pkg::FILT_PAETH), 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // bad filter code, then dropped bytes until the next image
    send_item(pru_pkg::FILT_MAX_CODE + 8'd1, 1'b0);
    send_item(8'h33, 1'b0);
    send_item(8'(pru_pkg::FILT_NONE), 1'b0);
    // restart in the middle of a row
    send_item(8'(pru_pkg::FILT_PAETH), 1'b1);
    send_item(8'h44, 1'b0);
    send_item(8'(pru_pkg::FILT_AVG), 1'b1);
    send_item(8'h10, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h30, 1'b0);
    send_item(8'hFF, 1'b0);
    wait_idle();
  endtask

  task automatic test_row_shortened();
    write_reg(pru_pkg::REG_ROW_BYTES, 14'd6);
    write_reg(pru_pkg::REG_PIXEL_BYTES, 14'd1);
    send_item(8'(pru_pkg::FILT_UP), 1'b1);
    repeat (4) send_item(8'($urandom), 1'b0);
    wait_idle();
    write_reg(pru_pkg::REG_ROW_BYTES, 14'd2);
    send_item(8'h5A, 1'b0);
    send_row(8'(pru_pkg::FILT_UP), 1'b0);
    send_row(8'(pru_pkg::FILT_SUB), 1'b0);
    wait_idle();
  endtask

  task automatic test_random_images();
    int                              target;
    logic [pru_pkg::ROW_BYTES_W-1:0] rb_val;
    target = live_items + RANDOM_ITEMS;
    while (live_items < target) begin
      wait_idle();
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(9))
          0:       rb_val = '0;
          1:       rb_val = 14'($urandom_range(25, 300));
          default: rb_val = 14'($urandom_range(1, 24));
        endcase
        write_reg(pru_pkg::REG_ROW_BYTES, rb_val);
        write_reg(pru_pkg::REG_PIXEL_BYTES, {10'($urandom), 4'($urandom_range(0, 15))});
      end
      gaps_on  = ($urandom_range(2) != 0);
      stall_on = ($urandom_range(2) != 0);
      send_image($urandom_range(1, 5), $urandom_range(3) != 0);
    end
    wait_idle();
  endtask

  task automatic test_wide_rows();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    write_reg(pru_pkg::REG_ROW_BYTES, 14'(pru_pkg::MAX_ROW_BYTES));
    write_reg(pru_pkg::REG_PIXEL_BYTES, 14'(pru_pkg::MAX_PIXEL_BYTES));
    send_item(8'(pru_pkg::FILT_PAETH), 1'b1);
    repeat (WIDE_ITEMS) send_item(8'($urandom), 1'b0);
    send_item(8'(pru_pkg::FILT_AVG), 1'b1);
    repeat (WIDE_ITEMS) send_item(8'($urandom), 1'b0);
    wait_idle();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    // all-ones values clamp to the maximum sizes
    write_reg(pru_pkg::REG_ROW_BYTES, 14'h3FFF);
    write_reg(pru_pkg::REG_PIXEL_BYTES, 14'h3FFF);
    repeat (WIDE_ITEMS) send_item(8'($urandom), 1'b0);
    wait_idle();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    write_reg(pru_pkg::REG_ROW_BYTES, 14'h0000);
    write_reg(pru_pkg::REG_PIXEL_BYTES, 14'h0000);
    send_row(8'(pru_pkg::FILT_SUB), 1'b1);
    send_row(8'(pru_pkg::FILT_PAETH), 1'b0);
    send_row(8'(pru_pkg::FILT_AVG), 1'b0);
    wait_idle();
  endtask

  task automatic test_quiet_tail();
    int target;
    quiet = 1'b1;
    write_reg(pru_pkg::REG_ROW_BYTES, 14'($urandom_range(1, 16)));
    write_reg(pru_pkg::REG_PIXEL_BYTES, 14'($urandom_range(1, 8)));
    target = live_items + TAIL_ITEMS;
    while (live_items < target) send_image($urandom_range(1, 4), 1'b1);
  endtask

  always @(negedge clk_i) begin
    if (quiet || !stall_on) begin
      out_stall_i = 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i = 1'b1;
    end else if ($urandom_range(4) == 0) begin
      stall_left  = $urandom_range(0, 7);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_output
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction: byte %02h row_end %0b status %0b",
                                  out_byte_o, row_end_o, status_o));
      end else begin
        want = expected_pixels.pop_front();
        if (out_byte_o !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, want.data));
        if (row_end_o !== want.last)
          report_mismatch($sformatf("row_end %0b, expected %0b", row_end_o, want.last));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0b, expected %0b", status_o, want.status));
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    row_bytes_q   = 14'd1;
    pixel_bytes_q = 4'd1;
    col_q         = 0;
    kind_q        = pru_pkg::FILT_NONE;
    want_filter   = 1'b1;
    first_line    = 1'b1;
    halted_q      = 1'b0;
    written_hw    = 0;
    foreach (left_px[i]) begin
      left_px[i]   = '0;
      upleft_px[i] = '0;
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_filter_types();
    test_row_shortened();
    test_random_images();
    test_wide_rows();
    test_quiet_tail();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
